[rtl/crcfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package crcfr_pkg;

    localparam logic [7:0]  START_BYTE = 8'h7E;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [7:0]  MIN_FRAME  = 8'd8;
    localparam int          LEN_INDEX  = 5;
    localparam int          LEN_W      = 7;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    // completed frame handed from the receive side to the emitter
    typedef struct packed {
        logic             start;
        logic             bad;
        logic [LEN_W-1:0] total;
    } emit_req_t;

    // reflected crc-16, one byte, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/crcfr_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module crcfr_store
    import crcfr_pkg::*;
#(
    parameter int MAX_FRAME = 64,
    localparam int AW = $clog2(MAX_FRAME)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [MAX_FRAME];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/crcfr_emit.sv]
`timescale 1ns / 1ps
`default_nettype none

module crcfr_emit
    import crcfr_pkg::*;
#(
    parameter int MAX_FRAME = 64,
    localparam int AW = $clog2(MAX_FRAME)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire emit_req_t        req,
    output logic                  idle,
    output logic                  rd_en,
    output logic     [AW-1:0]     rd_addr,
    input  wire logic [7:0]       rd_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic     [7:0]        m_out_byte,
    output logic     [5:0]        m_position,
    output logic     [LEN_W-1:0]  m_frame_length,
    output logic                  m_status,
    output logic                  m_last
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_READ,
        E_LOAD,
        E_ERR
    } emit_state_t;

    emit_state_t      state_reg;
    logic [AW-1:0]    idx_reg;
    logic [LEN_W-1:0] total_reg;
    logic             m_valid_reg;
    logic [7:0]       out_byte_reg;
    logic [5:0]       position_reg;
    logic [LEN_W-1:0] frame_length_reg;
    logic             status_reg;
    logic             last_reg;
    logic             out_free;
    logic             out_load;
    logic             at_last;

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = ((state_reg == E_LOAD) || (state_reg == E_ERR)) && out_free;
    assign at_last  = (LEN_W'(idx_reg) + LEN_W'(1)) == total_reg;

    assign idle    = (state_reg == E_IDLE);
    assign rd_en   = (state_reg == E_READ);
    assign rd_addr = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                E_IDLE: begin
                    if (req.start) begin
                        total_reg <= req.total;
                        idx_reg   <= '0;
                        state_reg <= req.bad ? E_ERR : E_READ;
                    end
                end
                E_READ: begin
                    state_reg <= E_LOAD;
                end
                E_LOAD: begin
                    // read data holds until the next read is issued
                    if (out_free) begin
                        out_byte_reg     <= rd_data;
                        position_reg     <= 6'(idx_reg);
                        frame_length_reg <= total_reg;
                        status_reg       <= STATUS_GOOD;
                        last_reg         <= at_last;
                        if (at_last) begin
                            state_reg <= E_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= E_READ;
                        end
                    end
                end
                E_ERR: begin
                    if (out_free) begin
                        out_byte_reg     <= 8'h00;
                        position_reg     <= 6'd0;
                        frame_length_reg <= total_reg;
                        status_reg       <= STATUS_BAD;
                        last_reg         <= 1'b1;
                        state_reg        <= E_IDLE;
                    end
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = out_byte_reg;
    assign m_position     = position_reg;
    assign m_frame_length = frame_length_reg;
    assign m_status       = status_reg;
    assign m_last         = last_reg;

endmodule

`default_nettype wire

[rtl/crc_checked_frame_reassembler_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream deframer with a CRC-16 check (reflected, poly 0xA001, init 0xFFFF).
// Input channel s_*: one transfer carries s_command and s_data_byte. A data byte
// is taken per cycle while s_ready is high; the reset command restarts the hunt
// for the 0x7E start byte. Byte 5 holds the total length (8 .. MAX_FRAME); a
// length out of range drops the partial frame without any result.
// Result channel m_*: a good frame comes out as frame_length transfers, one per
// byte in order, m_last on the final one; a CRC mismatch gives one transfer with
// m_status set and m_out_byte and m_position zero.
// Receiving a frame byte writes it into the frame store.
// When the last byte of a frame is taken, s_ready drops while the store is read
// back; each result byte is read, then loaded into the output register, and an
// error result is loaded without a store read. A stalled m_ready simply holds
// the output register and pauses the readback; s_ready returns as soon as the
// last result is loaded.
// Reset (aresetn low, synchronous) clears the fill count and CRC and empties
// the output register; frame store contents are not cleared.

module crc_checked_frame_reassembler_unit
    import crcfr_pkg::*;
#(
    parameter int MAX_FRAME = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_command,
    input  wire logic [7:0]       s_data_byte,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic     [7:0]        m_out_byte,
    output logic     [5:0]        m_position,
    output logic     [LEN_W-1:0]  m_frame_length,
    output logic                  m_status,
    output logic                  m_last
);

    localparam int AW = $clog2(MAX_FRAME);

    logic [AW-1:0]    fill_reg, fill_next;
    logic [15:0]      crc_reg, crc_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       prev_reg;
    logic             accept;
    logic             wr_en;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       rd_data;
    logic             emit_idle;
    emit_req_t        req;
    logic [7:0]       pos_ext;
    logic             covered;

    assign accept  = s_valid && s_ready;
    assign s_ready = emit_idle;
    assign pos_ext = 8'(fill_reg);
    assign covered = (pos_ext <= 8'(LEN_INDEX)) || ((pos_ext + 8'd2) < 8'(len_reg));

    always_comb begin
        fill_next = fill_reg;
        crc_next  = crc_reg;
        len_next  = len_reg;
        wr_en     = 1'b0;
        req       = '0;
        req.total = len_reg;
        if (accept) begin
            if (s_command == CMD_RESET) begin
                fill_next = '0;
                crc_next  = CRC_INIT;
            end else if (fill_reg != '0 || s_data_byte == START_BYTE) begin
                wr_en     = 1'b1;
                fill_next = fill_reg + AW'(1);
                if (covered) begin
                    crc_next = crc16_byte(crc_reg, s_data_byte);
                end
                if (pos_ext == 8'(LEN_INDEX)) begin
                    if (s_data_byte < MIN_FRAME || s_data_byte > 8'(MAX_FRAME)) begin
                        fill_next = '0;
                        crc_next  = CRC_INIT;
                    end else begin
                        len_next = LEN_W'(s_data_byte);
                    end
                end else if (pos_ext > 8'(LEN_INDEX)
                             && (pos_ext + 8'd1) == 8'(len_reg)) begin
                    // trailer is low byte first: previous byte, then this one
                    req.start = 1'b1;
                    req.bad   = (crc_reg != {s_data_byte, prev_reg});
                    fill_next = '0;
                    crc_next  = CRC_INIT;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            crc_reg  <= CRC_INIT;
        end else begin
            fill_reg <= fill_next;
            crc_reg  <= crc_next;
        end
        len_reg <= len_next;
        if (wr_en) begin
            prev_reg <= s_data_byte;
        end
    end

    // readback only runs while input is held off, so no write can hit a read
    crcfr_store #(
        .MAX_FRAME(MAX_FRAME)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg),
        .wr_data (s_data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    crcfr_emit #(
        .MAX_FRAME(MAX_FRAME)
    ) u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req            (req),
        .idle           (emit_idle),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_position     (m_position),
        .m_frame_length (m_frame_length),
        .m_status       (m_status),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire

[tb/sv/crc_checked_frame_reassembler_unit_tb.sv]
`timescale 1ns / 1ps

module crc_checked_frame_reassembler_unit_tb;
    import crcfr_pkg::*;

    localparam int MAX_FRAME = 64;
    localparam int DIR_ROWS  = 25;

    typedef struct packed {
        logic [7:0]       res_byte;
        logic [5:0]       res_pos;
        logic [LEN_W-1:0] res_len;
        logic             res_status;
        logic             res_last;
    } frame_result_t;

    // where a directed byte comes from: typed in, or the live check value
    typedef enum {SRC_LIT, SRC_CHK_LO, SRC_CHK_HI} byte_src_t;
    typedef enum {OUT_PREDICT, OUT_NONE, OUT_ERROR} outcome_t;

    typedef struct {
        logic       cmd;
        byte_src_t  src;
        logic [7:0] data;
        outcome_t   outcome;
        int         err_len;
    } dir_row_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_command = CMD_DATA;
    logic [7:0]       s_data_byte = 8'h00;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [7:0]       m_out_byte;
    logic [5:0]       m_position;
    logic [LEN_W-1:0] m_frame_length;
    logic             m_status;
    logic             m_last;

    // predictor state
    logic [7:0]  pred_store [MAX_FRAME];
    int          pred_fill = 0;
    logic [15:0] pred_chk = CRC_INIT;

    frame_result_t frame_results_due [$];
    int            last_result_count;
    int            taken_items = 0;
    int            mismatches = 0;

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // hunting byte, then a start cut short by the reset command
        '{CMD_DATA,  SRC_LIT,    8'hFF, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'h7E, OUT_NONE,    0},
        '{CMD_RESET, SRC_LIT,    8'hFF, OUT_NONE,    0},
        // minimum length frame with a zero trailer: checksum mismatch
        '{CMD_DATA,  SRC_LIT,    8'h7E, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'h00, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'hFF, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'h80, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'h01, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'h08, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'h00, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'h00, OUT_ERROR,   8},
        // length byte 0x7e is too long and must not restart the hunt
        '{CMD_DATA,  SRC_LIT,    8'h7E, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'h11, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'h22, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'h33, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'h44, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'h7E, OUT_NONE,    0},
        // good minimum length frame
        '{CMD_DATA,  SRC_LIT,    8'h7E, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'h5A, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'hA5, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'h00, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'hFF, OUT_NONE,    0},
        '{CMD_DATA,  SRC_LIT,    8'h08, OUT_NONE,    0},
        '{CMD_DATA,  SRC_CHK_LO, 8'h00, OUT_NONE,    0},
        '{CMD_DATA,  SRC_CHK_HI, 8'h00, OUT_PREDICT, 0}
    };

    crc_checked_frame_reassembler_unit #(
        .MAX_FRAME(MAX_FRAME)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_position    (m_position),
        .m_frame_length(m_frame_length),
        .m_status      (m_status),
        .m_last        (m_last)
    );

    always #5 aclk = ~aclk;

    // bitwise form of the reflected crc-16
    function automatic logic [15:0] crc16_step(input logic [15:0] acc,
                                               input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ data[k];
            c = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void clear_reassembly();
        pred_fill = 0;
        pred_chk = CRC_INIT;
    endfunction

    // takes one accepted transfer, queues the results it causes
    function automatic int deframe_step(input logic cmd, input logic [7:0] data);
        int            pos;
        int            total;
        logic [15:0]   trailer;
        logic [15:0]   chk;
        frame_result_t r;
        if (cmd == CMD_RESET) begin
            clear_reassembly();
            taken_items++;
            return 0;
        end
        if (pred_fill == 0 && data != START_BYTE) begin
            return 0;
        end
        taken_items++;
        pos = pred_fill;
        pred_store[pos] = data;
        pred_fill = pos + 1;
        if (pos <= LEN_INDEX || pos + 2 < int'(pred_store[LEN_INDEX])) begin
            pred_chk = crc16_step(pred_chk, data);
        end
        if (pred_fill <= LEN_INDEX) begin
            return 0;
        end
        total = int'(pred_store[LEN_INDEX]);
        if (total < int'(MIN_FRAME) || total > MAX_FRAME) begin
            clear_reassembly();
            return 0;
        end
        if (pred_fill < total) begin
            return 0;
        end
        trailer = {pred_store[total-1], pred_store[total-2]};
        chk = pred_chk;
        clear_reassembly();
        if (chk == trailer) begin
            for (int i = 0; i < total; i++) begin
                r.res_byte = pred_store[i];
                r.res_pos = 6'(i);
                r.res_len = LEN_W'(total);
                r.res_status = STATUS_GOOD;
                r.res_last = (i + 1 == total);
                frame_results_due.push_back(r);
            end
            return total;
        end
        r.res_byte = 8'h00;
        r.res_pos = 6'd0;
        r.res_len = LEN_W'(total);
        r.res_status = STATUS_BAD;
        r.res_last = 1'b1;
        frame_results_due.push_back(r);
        return 1;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // offer one transfer and hold it until taken, then maybe go idle
    task automatic push_item(input logic cmd, input logic [7:0] data);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_data_byte <= data;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        last_result_count = deframe_step(cmd, data);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            s_command <= 1'($urandom);
            s_data_byte <= 8'($urandom);
            @(posedge aclk);
        end
    endtask

    task automatic resync();
        if (pred_fill != 0) begin
            push_item(CMD_RESET, 8'($urandom));
        end
    endtask

    // well-formed frame with random content; optional corruption or early reset
    task automatic send_frame(input int len, input bit corrupt, input int cut_at);
        logic [7:0]  fb [MAX_FRAME];
        logic [15:0] chk;
        int          idx;
        resync();
        fb[0] = START_BYTE;
        for (int i = 1; i < len; i++) begin
            fb[i] = 8'($urandom);
        end
        fb[LEN_INDEX] = 8'(len);
        chk = CRC_INIT;
        for (int i = 0; i < len - 2; i++) begin
            chk = crc16_step(chk, fb[i]);
        end
        fb[len-2] = chk[7:0];
        fb[len-1] = chk[15:8];
        if (corrupt) begin
            idx = $urandom_range(len - 1, 1);
            if (idx == LEN_INDEX) begin
                idx = LEN_INDEX + 1;
            end
            fb[idx] = fb[idx] ^ (8'h01 << $urandom_range(7, 0));
        end
        for (int i = 0; i < len; i++) begin
            if (i == cut_at) begin
                push_item(CMD_RESET, 8'($urandom));
                break;
            end
            push_item(CMD_DATA, fb[i]);
        end
    endtask

    task automatic run_random(input int target);
        int first;
        int pick;
        int len;
        first = taken_items;
        while (taken_items - first < target) begin
            pick = $urandom_range(99, 0);
            len = $urandom_range(19, 0);
            len = (len == 0) ? MAX_FRAME : (len < 4) ? int'(MIN_FRAME) : $urandom_range(16, 9);
            if (pick < 60) begin
                send_frame(len, 1'b0, -1);
            end else if (pick < 75) begin
                send_frame(len, 1'b1, -1);
            end else if (pick < 85) begin
                send_frame(len, 1'b0, $urandom_range(len - 1, 1));
            end else if (pick < 93) begin
                // length byte out of range
                resync();
                push_item(CMD_DATA, START_BYTE);
                repeat (4) push_item(CMD_DATA, 8'($urandom));
                if ($urandom_range(1, 0) == 0) begin
                    push_item(CMD_DATA, 8'($urandom_range(7, 0)));
                end else begin
                    push_item(CMD_DATA, 8'($urandom_range(255, MAX_FRAME + 1)));
                end
            end else begin
                repeat ($urandom_range(3, 1)) begin
                    push_item(($urandom_range(9, 0) == 0) ? CMD_RESET : CMD_DATA,
                              8'($urandom));
                end
            end
        end
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        while (frame_results_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_results_due.size() == 0) begin
                $error("result transfer with nothing expected: byte 0x%0h pos %0d",
                       m_out_byte, m_position);
                mismatches++;
            end else begin
                want = frame_results_due.pop_front();
                check_field("m_out_byte", want.res_byte, m_out_byte);
                check_field("m_position", want.res_pos, m_position);
                check_field("m_frame_length", want.res_len, m_frame_length);
                check_field("m_status", want.res_status, m_status);
                check_field("m_last", want.res_last, m_last);
            end
        end
    end

    initial begin
        logic [7:0]    d;
        frame_result_t r;
        int            idle_tab [4];
        int            stall_tab [4];
        idle_tab = '{0, 45, 0, 30};
        stall_tab = '{0, 0, 45, 30};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            case (dir_rows[i].src)
                SRC_CHK_LO: d = pred_chk[7:0];
                SRC_CHK_HI: d = pred_chk[15:8];
                default:    d = dir_rows[i].data;
            endcase
            push_item(dir_rows[i].cmd, d);
            if (dir_rows[i].outcome == OUT_NONE) begin
                check_field("result count", 0, last_result_count);
            end else if (dir_rows[i].outcome == OUT_ERROR) begin
                check_field("result count", 1, last_result_count);
                if (last_result_count == 1) begin
                    r = frame_results_due[$];
                    check_field("error out_byte", 0, r.res_byte);
                    check_field("error position", 0, r.res_pos);
                    check_field("error frame_length", dir_rows[i].err_len, r.res_len);
                    check_field("error status", STATUS_BAD, r.res_status);
                    check_field("error last", 1, r.res_last);
                end
            end
        end

        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            run_random(5);
            if (p == 1) begin
                // long receiver hold-off while full frames keep coming
                sender_idle_pct = 0;
                recv_stall_pct = 0;
                hold_reqs++;
                send_frame(MAX_FRAME, 1'b0, -1);
                send_frame(int'(MIN_FRAME), 1'b0, -1);
                pause_until_drained();
                repeat (20) @(posedge aclk);
            end
        end

        pause_until_drained();
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
